[hw/rtl/pdm_pkg.sv]
`timescale 1ns / 1ps
package pdm_pkg;

  localparam int FIELD_W       = 18;
  localparam int FRAC_BITS_DEF = 16;
  // quotient bits per part: rounding bit, 18 value bits and an overflow bit
  localparam int QB            = FIELD_W + 2;
  localparam int DATA_W        = 40;
  localparam int CFG_IDX_W     = 2;
  localparam int OUT_MAX       = (1 << (FIELD_W - 1)) - 1;
  localparam int OUT_MIN_MAG   = 1 << (FIELD_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_RE,
    REG_SHIFT_IM,
    REG_PHASE_RE,
    REG_PHASE_IM
  } pdm_reg_t;

  typedef struct packed {
    logic last;
    logic zero;
    logic neg_re;
    logic neg_im;
  } pdm_ctrl_t;

  // denominator part width (real and imaginary of 1 - conj(a)*z)
  function automatic int drw(input int f);
    return ((2 * FIELD_W + 1 > 2 * f + 2) ? 2 * FIELD_W + 1 : 2 * f + 2) + 1;
  endfunction

  // numerator part width before the multiply by conj(den)
  function automatic int prw();
    return 2 * FIELD_W + 2;
  endfunction

endpackage

[hw/rtl/pdm_mul_split.sv]
`timescale 1ns / 1ps
module pdm_mul_split #(
  parameter int AW = 38,
  parameter int BW = 38
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  localparam int LOW = (BW + 1) / 2;
  localparam int HIW = BW - LOW;

  logic signed [LOW:0]        b_lo;
  logic signed [HIW-1:0]      b_hi;
  logic signed [AW+LOW:0]     lo_r;
  logic signed [AW+HIW-1:0]   hi_r;
  logic signed [AW+BW-1:0]    lo_ext;
  logic signed [AW+BW-1:0]    hi_sh;
  logic signed [AW+BW-1:0]    p_r;

  assign b_lo = {1'b0, b[LOW-1:0]};
  assign b_hi = b[BW-1:LOW];

  // first register stage: two half-width partial products
  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= a * b_lo;
      hi_r <= a * b_hi;
    end
  end

  assign lo_ext = {{(BW-LOW-1){lo_r[AW+LOW]}}, lo_r};
  assign hi_sh  = {hi_r, {LOW{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= hi_sh + lo_ext;
    end
  end

  assign p = p_r;
endmodule

[hw/rtl/pdm_front.sv]
`timescale 1ns / 1ps
module pdm_front #(
  parameter int FRAC_BITS = pdm_pkg::FRAC_BITS_DEF,
  parameter int DRW  = pdm_pkg::drw(FRAC_BITS),
  parameter int PRW  = pdm_pkg::prw(),
  parameter int QW   = PRW + DRW + 1,
  parameter int DENW = 2 * DRW
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic signed [pdm_pkg::FIELD_W-1:0] x,
  input  logic signed [pdm_pkg::FIELD_W-1:0] y,
  input  logic last,
  input  logic signed [pdm_pkg::FIELD_W-1:0] ar,
  input  logic signed [pdm_pkg::FIELD_W-1:0] ai,
  input  logic signed [pdm_pkg::FIELD_W-1:0] cr,
  input  logic signed [pdm_pkg::FIELD_W-1:0] ci,
  output logic out_valid,
  output pdm_pkg::pdm_ctrl_t out_ctrl,
  output logic [QW-1:0]   num_re,
  output logic [QW-1:0]   num_im,
  output logic [DENW-1:0] den
);
  import pdm_pkg::*;

  localparam logic signed [DRW-1:0] ONE_SQ = {{(DRW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

  // stage 1: a*z products, z - a
  logic v1_r, last1_r;
  logic signed [2*FIELD_W-1:0] arx1_r, aiy1_r, ary1_r, aix1_r;
  logic signed [FIELD_W:0] nr1_r, ni1_r;
  // stage 2: denominator, phase products
  logic v2_r, last2_r;
  logic signed [DRW-1:0] dr2_r, di2_r;
  logic signed [2*FIELD_W:0] crnr2_r, cini2_r, crni2_r, cinr2_r;
  // stage 3: numerator
  logic v3_r, last3_r, zero3_r;
  logic signed [PRW-1:0] pr3_r, pi3_r;
  logic signed [DRW-1:0] dr3_r, di3_r;
  // stages 4-5: wide products
  logic v4_r, v5_r, last4_r, last5_r, zero4_r, zero5_r;
  logic signed [2*DRW-1:0]   sqr5, sqi5;
  logic signed [PRW+DRW-1:0] prdr5, pidi5, pidr5, prdi5;
  // stage 6: sums
  logic v6_r, last6_r, zero6_r;
  logic signed [2*DRW:0] den_sum;
  logic [DENW-1:0] den6_r;
  logic signed [QW-1:0] qr6_r, qi6_r;
  // stage 7: magnitudes
  logic v7_r;
  pdm_ctrl_t ctrl7_r;
  logic [QW-1:0] nre7_r, nim7_r;
  logic [DENW-1:0] den7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last1_r <= last;
      arx1_r  <= ar * x;
      aiy1_r  <= ai * y;
      ary1_r  <= ar * y;
      aix1_r  <= ai * x;
      nr1_r   <= x - ar;
      ni1_r   <= y - ai;

      last2_r <= last1_r;
      dr2_r   <= ONE_SQ - (arx1_r + aiy1_r);
      di2_r   <= aix1_r - ary1_r;
      crnr2_r <= cr * nr1_r;
      cini2_r <= ci * ni1_r;
      crni2_r <= cr * ni1_r;
      cinr2_r <= ci * nr1_r;

      last3_r <= last2_r;
      zero3_r <= (dr2_r == '0) && (di2_r == '0);
      pr3_r   <= crnr2_r - cini2_r;
      pi3_r   <= crni2_r + cinr2_r;
      dr3_r   <= dr2_r;
      di3_r   <= di2_r;

      last4_r <= last3_r;
      zero4_r <= zero3_r;
      last5_r <= last4_r;
      zero5_r <= zero4_r;

      last6_r <= last5_r;
      zero6_r <= zero5_r;
      den6_r  <= den_sum[DENW-1:0];
      qr6_r   <= prdr5 + pidi5;
      qi6_r   <= pidr5 - prdi5;

      ctrl7_r.last   <= last6_r;
      ctrl7_r.zero   <= zero6_r;
      ctrl7_r.neg_re <= qr6_r[QW-1];
      ctrl7_r.neg_im <= qi6_r[QW-1];
      nre7_r <= qr6_r[QW-1] ? QW'(-qr6_r) : QW'(qr6_r);
      nim7_r <= qi6_r[QW-1] ? QW'(-qi6_r) : QW'(qi6_r);
      den7_r <= den6_r;
    end
  end

  assign den_sum = sqr5 + sqi5;

  pdm_mul_split #(.AW(DRW), .BW(DRW)) u_sqr (
    .clk(clk), .en(en), .a(dr3_r), .b(dr3_r), .p(sqr5));
  pdm_mul_split #(.AW(DRW), .BW(DRW)) u_sqi (
    .clk(clk), .en(en), .a(di3_r), .b(di3_r), .p(sqi5));
  pdm_mul_split #(.AW(PRW), .BW(DRW)) u_prdr (
    .clk(clk), .en(en), .a(pr3_r), .b(dr3_r), .p(prdr5));
  pdm_mul_split #(.AW(PRW), .BW(DRW)) u_pidi (
    .clk(clk), .en(en), .a(pi3_r), .b(di3_r), .p(pidi5));
  pdm_mul_split #(.AW(PRW), .BW(DRW)) u_pidr (
    .clk(clk), .en(en), .a(pi3_r), .b(dr3_r), .p(pidr5));
  pdm_mul_split #(.AW(PRW), .BW(DRW)) u_prdi (
    .clk(clk), .en(en), .a(pr3_r), .b(di3_r), .p(prdi5));

  assign out_valid = v7_r;
  assign out_ctrl  = ctrl7_r;
  assign num_re    = nre7_r;
  assign num_im    = nim7_r;
  assign den       = den7_r;
endmodule

[hw/rtl/pdm_divider.sv]
`timescale 1ns / 1ps
module pdm_divider #(
  parameter int FRAC_BITS = pdm_pkg::FRAC_BITS_DEF,
  parameter int NW = 77,
  parameter int DW = 76
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  pdm_pkg::pdm_ctrl_t in_ctrl,
  input  logic [NW-1:0] num_re,
  input  logic [NW-1:0] num_im,
  input  logic [DW-1:0] den,
  output logic out_valid,
  output pdm_pkg::pdm_ctrl_t out_ctrl,
  output logic [pdm_pkg::QB-1:0] q_re,
  output logic [pdm_pkg::QB-1:0] q_im
);
  import pdm_pkg::*;

  localparam int RW = ((NW + FRAC_BITS + 1 > DW + QB) ? NW + FRAC_BITS + 1 : DW + QB) + 1;

  logic            v_r   [QB];
  pdm_ctrl_t       ctl_r [QB];
  logic [RW-1:0]   rre_r [QB];
  logic [RW-1:0]   rim_r [QB];
  logic [DW-1:0]   den_r [QB];
  logic [QB-1:0]   qre_r [QB];
  logic [QB-1:0]   qim_r [QB];

  logic            v_i   [QB];
  pdm_ctrl_t       ctl_i [QB];
  logic [RW-1:0]   rre_i [QB];
  logic [RW-1:0]   rim_i [QB];
  logic [DW-1:0]   den_i [QB];
  logic [QB-1:0]   qre_i [QB];
  logic [QB-1:0]   qim_i [QB];

  // one restoring step per stage, quotient msb first (msb flags overflow)
  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RW-1:0] dsh;
    logic          ge_re, ge_im;

    if (s == 0) begin : g_first
      assign v_i[s]   = in_valid;
      assign ctl_i[s] = in_ctrl;
      assign rre_i[s] = RW'(num_re) << (FRAC_BITS + 1);
      assign rim_i[s] = RW'(num_im) << (FRAC_BITS + 1);
      assign den_i[s] = den;
      assign qre_i[s] = '0;
      assign qim_i[s] = '0;
    end else begin : g_next
      assign v_i[s]   = v_r[s-1];
      assign ctl_i[s] = ctl_r[s-1];
      assign rre_i[s] = rre_r[s-1];
      assign rim_i[s] = rim_r[s-1];
      assign den_i[s] = den_r[s-1];
      assign qre_i[s] = qre_r[s-1];
      assign qim_i[s] = qim_r[s-1];
    end

    assign dsh   = RW'(den_i[s]) << (QB - 1 - s);
    assign ge_re = rre_i[s] >= dsh;
    assign ge_im = rim_i[s] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[s] <= ctl_i[s];
        den_r[s] <= den_i[s];
        rre_r[s] <= ge_re ? rre_i[s] - dsh : rre_i[s];
        rim_r[s] <= ge_im ? rim_i[s] - dsh : rim_i[s];
        qre_r[s] <= {qre_i[s][QB-2:0], ge_re};
        qim_r[s] <= {qim_i[s][QB-2:0], ge_im};
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_ctrl  = ctl_r[QB-1];
  assign q_re      = qre_r[QB-1];
  assign q_im      = qim_r[QB-1];
endmodule

[hw/rtl/poincare_disk_mobius_map.sv]
// Poincare disk Mobius map: z' = p*(z - a) / (1 - conj(a)*z), signed Q2.16.
// Pipeline from input beat to result beat: front stages, divider stages, then the output register.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or taken, so a stall on the output holds every stage.
// Reset (rst_n low, synchronous): pipeline valids clear, a = 0, p = 1.0.
`timescale 1ns / 1ps
module poincare_disk_mobius_map #(
  parameter int FRAC_BITS = pdm_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // input channel; tdata: x_in [17:0], y_in [35:18], zero pad [39:36]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pdm_pkg::DATA_W-1:0]  in_tdata,
  input  logic                        in_tlast,
  // result channel; tdata: x_out [17:0], y_out [35:18], zero pad [39:36]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pdm_pkg::DATA_W-1:0]  out_tdata,
  output logic                        out_tuser,   // map_error
  output logic                        out_tlast,   // last_out
  // configuration write port
  input  logic                            cfg_we,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdm_pkg::FIELD_W-1:0]     cfg_wdata
);
  import pdm_pkg::*;

  localparam int DRW  = drw(FRAC_BITS);
  localparam int PRW  = prw();
  localparam int QW   = PRW + DRW + 1;
  localparam int DENW = 2 * DRW;
  localparam logic [FIELD_W-1:0] PHASE_RST = FIELD_W'(64'd1 << FRAC_BITS);

  // config registers
  logic signed [FIELD_W-1:0] shift_re_r, shift_im_r, phase_re_r, phase_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_re_r <= '0;
      shift_im_r <= '0;
      phase_re_r <= PHASE_RST;
      phase_im_r <= '0;
    end else if (cfg_we) begin
      unique case (pdm_reg_t'(cfg_index))
        REG_SHIFT_RE: shift_re_r <= cfg_wdata;
        REG_SHIFT_IM: shift_im_r <= cfg_wdata;
        REG_PHASE_RE: phase_re_r <= cfg_wdata;
        REG_PHASE_IM: phase_im_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being drained
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic                 f_valid;
  pdm_ctrl_t            f_ctrl;
  logic [QW-1:0]        f_num_re, f_num_im;
  logic [DENW-1:0]      f_den;

  pdm_front #(.FRAC_BITS(FRAC_BITS), .DRW(DRW), .PRW(PRW), .QW(QW), .DENW(DENW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .x        (in_tdata[FIELD_W-1:0]),
    .y        (in_tdata[2*FIELD_W-1:FIELD_W]),
    .last     (in_tlast),
    .ar       (shift_re_r),
    .ai       (shift_im_r),
    .cr       (phase_re_r),
    .ci       (phase_im_r),
    .out_valid(f_valid),
    .out_ctrl (f_ctrl),
    .num_re   (f_num_re),
    .num_im   (f_num_im),
    .den      (f_den)
  );

  logic            d_valid;
  pdm_ctrl_t       d_ctrl;
  logic [QB-1:0]   d_q_re, d_q_im;

  pdm_divider #(.FRAC_BITS(FRAC_BITS), .NW(QW), .DW(DENW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid),
    .in_ctrl  (f_ctrl),
    .num_re   (f_num_re),
    .num_im   (f_num_im),
    .den      (f_den),
    .out_valid(d_valid),
    .out_ctrl (d_ctrl),
    .q_re     (d_q_re),
    .q_im     (d_q_im)
  );

  // round half away from zero on the doubled quotient, then clamp.
  // returns {saturated, value}
  function automatic logic [FIELD_W:0] part_val(input logic [QB-1:0] q, input logic neg);
    logic [QB-1:0]      inc;
    logic [QB-2:0]      m;
    logic [QB-1:0]      negm;
    logic               sat;
    logic [FIELD_W-1:0] val;
    inc  = {1'b0, q[QB-2:0]} + QB'(1);
    m    = inc[QB-1:1];
    negm = ~{1'b0, m} + QB'(1);
    if (neg) begin
      sat = q[QB-1] || (m > (QB-1)'(OUT_MIN_MAG));
      val = sat ? FIELD_W'(OUT_MIN_MAG) : negm[FIELD_W-1:0];
    end else begin
      sat = q[QB-1] || (m > (QB-1)'(OUT_MAX));
      val = sat ? FIELD_W'(OUT_MAX) : m[FIELD_W-1:0];
    end
    return {sat, val};
  endfunction

  logic [FIELD_W:0]   pv_re, pv_im;
  logic [FIELD_W-1:0] x_out_r, y_out_r;
  logic               err_r, last_r;

  assign pv_re = part_val(d_q_re, d_ctrl.neg_re);
  assign pv_im = part_val(d_q_im, d_ctrl.neg_im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  // zero denominator forces a zero result with the error flag
  always_ff @(posedge clk) begin
    if (en) begin
      x_out_r <= d_ctrl.zero ? '0 : pv_re[FIELD_W-1:0];
      y_out_r <= d_ctrl.zero ? '0 : pv_im[FIELD_W-1:0];
      err_r   <= d_ctrl.zero || pv_re[FIELD_W] || pv_im[FIELD_W];
      last_r  <= d_ctrl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(DATA_W-2*FIELD_W){1'b0}}, y_out_r, x_out_r};
  assign out_tuser  = err_r;
  assign out_tlast  = last_r;
endmodule

[hw/rtl/pdm_checker.sv]
`timescale 1ns / 1ps
module pdm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [pdm_pkg::DATA_W-1:0] out_tdata,
  input logic out_tuser,
  input logic out_tlast
);
  import pdm_pkg::*;

  logic [FIELD_W-1:0] xo, yo;
  logic               rail;
  assign xo   = out_tdata[FIELD_W-1:0];
  assign yo   = out_tdata[2*FIELD_W-1:FIELD_W];
  assign rail = (xo == '0 && yo == '0) ||
                xo == FIELD_W'(OUT_MAX) || xo == FIELD_W'(OUT_MIN_MAG) ||
                yo == FIELD_W'(OUT_MAX) || yo == FIELD_W'(OUT_MIN_MAG);

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output drain");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_err_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> rail)
    else $error("error flag without clamped or zero result");
endmodule

bind poincare_disk_mobius_map pdm_checker u_pdm_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import pdm_pkg::*;

  localparam int  FRAC       = 16;
  localparam int  PIPE_DEPTH = 28;        // input beat to result beat
  localparam int  DRAIN_WAIT = 2 * PIPE_DEPTH + 8;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam logic signed [17:0] F_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] F_MIN = 18'sh20000;
  localparam logic signed [17:0] ONE   = 18'sd65536;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               err;
    logic               last;
  } mapped_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;
  logic                out_tuser;
  logic                out_tlast;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]  cfg_wdata = '0;

  poincare_disk_mobius_map DUT (.*);

  always #5 clk = ~clk;

  // shadow copies of the register file
  logic signed [17:0] a_re, a_im, p_re, p_im;

  mapped_pt_t pending_pts[$];
  int  send_idle_pct = 0;   // chance (%) the sender skips a cycle
  int  stall_pct = 0;       // chance (%) the receiver stalls a cycle
  int  hold_cycles = 0;     // forced receiver hold-off
  int  n_sent = 0, n_checked = 0, n_errflag = 0, n_fail = 0;
  longint cycles = 0;

  // Rounds |q|/den to FRAC bits, ties away from zero, and saturates to 18 bits.
  function automatic logic [17:0] round_part(input logic signed [127:0] q,
                                             input logic signed [127:0] den,
                                             inout logic err);
    logic         neg;
    logic [127:0] mag;
    logic [159:0] t, m;
    neg = q < 0;
    mag = neg ? -q : q;
    t = ({32'b0, mag} << (FRAC + 1)) / {32'b0, den};
    m = (t + 1) >> 1;
    if (!neg && m > 160'd131071) begin
      err = 1'b1;
      return F_MAX;
    end
    if (neg && m > 160'd131072) begin
      err = 1'b1;
      return F_MIN;
    end
    return neg ? -m[17:0] : m[17:0];
  endfunction

  // z' = p*(z - a) / (1 - conj(a)*z), exact integer math
  function automatic mapped_pt_t mobius_map(input logic signed [17:0] x,
                                            input logic signed [17:0] y,
                                            input logic lst);
    longint xs, ys, ar, ai, cr, ci, nr, ni, pr, pi, dr, di;
    logic signed [127:0] wpr, wpi, wdr, wdi, den, qr, qi;
    mapped_pt_t r;
    xs = x; ys = y; ar = a_re; ai = a_im; cr = p_re; ci = p_im;
    nr = xs - ar;
    ni = ys - ai;
    pr = cr * nr - ci * ni;
    pi = cr * ni + ci * nr;
    dr = (64'sd1 <<< (2 * FRAC)) - (ar * xs + ai * ys);
    di = -(ar * ys - ai * xs);
    r.x = '0; r.y = '0; r.err = 1'b0; r.last = lst;
    if (dr == 0 && di == 0) begin
      r.err = 1'b1;
    end else begin
      wpr = pr; wpi = pi; wdr = dr; wdi = di;
      den = wdr * wdr + wdi * wdi;
      qr = wpr * wdr + wpi * wdi;
      qi = wpi * wdr - wpr * wdi;
      r.x = round_part(qr, den, r.err);
      r.y = round_part(qi, den, r.err);
    end
    return r;
  endfunction

  // result checker: every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    mapped_pt_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected result beat: x_out=%0d", $signed(out_tdata[17:0]));
        n_fail++;
      end else begin
        e = pending_pts.pop_front();
        n_checked++;
        if (e.err) n_errflag++;
        if (out_tdata[17:0] !== e.x) begin
          $error("x_out: expected %0d, got %0d", e.x, $signed(out_tdata[17:0]));
          n_fail++;
        end
        if (out_tdata[35:18] !== e.y) begin
          $error("y_out: expected %0d, got %0d", e.y, $signed(out_tdata[35:18]));
          n_fail++;
        end
        if (out_tuser !== e.err) begin
          $error("map_error: expected %0b, got %0b", e.err, out_tuser);
          n_fail++;
        end
        if (out_tlast !== e.last) begin
          $error("last_out: expected %0b, got %0b", e.last, out_tlast);
          n_fail++;
        end
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_pts.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // one input beat; valid stays high into the next call unless it idles
  task automatic send_point(input logic signed [17:0] x, input logic signed [17:0] y,
                            input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {4'b0, y, x};
    in_tlast  = lst;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_pts.push_back(mobius_map(x, y, lst));
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_pts.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // write while idle only
  task automatic write_reg(input pdm_reg_t idx, input logic signed [17:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SHIFT_RE: a_re = val;
      REG_SHIFT_IM: a_im = val;
      REG_PHASE_RE: p_re = val;
      REG_PHASE_IM: p_im = val;
      default: ;
    endcase
  endtask

  task automatic set_map(input logic signed [17:0] ar, ai, cr, ci);
    wait_drained();
    write_reg(REG_SHIFT_RE, ar);
    write_reg(REG_SHIFT_IM, ai);
    write_reg(REG_PHASE_RE, cr);
    write_reg(REG_PHASE_IM, ci);
  endtask

  function automatic logic signed [17:0] rnd_full();
    return 18'($urandom());
  endfunction

  // mostly inside the unit disk (|coord| < ~0.7), sometimes full range
  function automatic logic signed [17:0] rnd_coord();
    if ($urandom_range(9) == 0) return rnd_full();
    return $signed(18'($urandom_range(92000))) - 18'sd46000;
  endfunction

  // reset values: a = 0, p = 1 -> identity map
  task automatic test_identity();
    send_point(18'sd0, 18'sd0, 1'b0);
    send_point(F_MAX, F_MIN, 1'b0);
    send_point(F_MIN, F_MAX, 1'b1);
    send_point(18'sd12345, -18'sd777, 1'b0);
  endtask

  task automatic test_rotation();
    set_map(18'sd0, 18'sd0, 18'sd0, ONE);          // quarter turn
    send_point(ONE, 18'sd0, 1'b0);
    send_point(18'sd32768, -18'sd1, 1'b0);
    send_point(F_MIN, F_MIN, 1'b1);                // real part saturates
    set_map(18'sd0, 18'sd0, 18'sd46341, -18'sd46341);
    send_point(18'sd1, 18'sd1, 1'b0);
    send_point(F_MIN, 18'sd0, 1'b1);
  endtask

  task automatic test_translation();
    set_map(18'sd32768, -18'sd16384, ONE, 18'sd0);
    send_point(18'sd0, 18'sd0, 1'b0);
    send_point(18'sd32768, -18'sd16384, 1'b0);    // z = a -> 0
    send_point(-18'sd60000, 18'sd20000, 1'b1);
    send_point(F_MAX, F_MIN, 1'b0);
  endtask

  task automatic test_zero_denominator();
    set_map(ONE, 18'sd0, ONE, 18'sd0);             // a = 1
    send_point(ONE, 18'sd0, 1'b1);                 // 1 - conj(a)z = 0
    send_point(ONE - 18'sd1, 18'sd0, 1'b0);        // tiny denominator, maps to -1
    set_map(18'sd0, -ONE, ONE, 18'sd0);            // a = -i
    send_point(18'sd0, ONE, 1'b0);                 // conj(a)z = i*i = -1, denominator 2
    send_point(F_MIN, F_MIN, 1'b1);
  endtask

  task automatic test_extreme_regs();
    set_map(F_MAX, F_MIN, F_MIN, F_MAX);
    send_point(F_MAX, F_MAX, 1'b0);
    send_point(F_MIN, F_MIN, 1'b1);
    send_point(18'sd0, 18'sd0, 1'b0);
    set_map(F_MIN, F_MAX, F_MAX, F_MIN);
    send_point(18'sd1, -18'sd1, 1'b1);
  endtask

  task automatic random_block(input int count);
    repeat (count) send_point(rnd_coord(), rnd_coord(), $urandom_range(7) == 0);
  endtask

  // random settings, walking through the idling profiles
  task automatic test_random_maps();
    int prof;
    for (int s = 0; s < 8; s++) begin
      if (s % 4 == 3)
        set_map(rnd_full(), rnd_full(), rnd_full(), rnd_full());
      else
        set_map(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      for (prof = 0; prof < 4; prof++) begin
        send_idle_pct = (prof == 1 || prof == 3) ? ((prof == 3) ? 20 : 84) : 0;
        stall_pct     = (prof == 2 || prof == 3) ? ((prof == 3) ? 20 : 84) : 0;
        random_block(40);
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // long receiver hold-off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    set_map(18'sd20000, 18'sd9000, 18'sd56756, 18'sd32768);
    @(negedge clk);
    hold_cycles = 300;
    random_block(120);
    wait_drained();          // sender pauses until every result is back
    random_block(60);
  endtask

  initial begin
    a_re = '0; a_im = '0; p_re = ONE; p_im = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_identity();
    test_rotation();
    test_translation();
    test_zero_denominator();
    test_extreme_regs();
    test_random_maps();
    test_backpressure();
    wait_drained();

    $display("covered %0d points: identity, rotation, translation, zero denominator,",
             n_sent);
    $display("extreme and random maps under stalls; %0d results checked, %0d flagged",
             n_checked, n_errflag);
    if (n_fail == 0 && pending_pts.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
